// ===== src/utf8_byte_stream_decoder_assert.svh =====
// Assertion macros for the UTF-8 byte stream decoder.
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define U8D_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("u8d check failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define U8D_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("u8d check failed: next-cycle implication");

`endif

// ===== src/u8d_pkg.sv =====
// Types and constants shared by the UTF-8 decoder modules.
package u8d_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned PointW = 21;
    localparam int unsigned RemW   = 2;

    // Lead byte patterns and masks
    localparam logic [ByteW-1:0] ContMask  = 8'hC0;
    localparam logic [ByteW-1:0] ContCode  = 8'h80;
    localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
    localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
    localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
    localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
    localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
    localparam logic [ByteW-1:0] Lead4Code = 8'hF0;
    localparam logic [ByteW-1:0] Ascii1Bit = 8'h80;
    localparam logic [ByteW-1:0] Pay2Mask  = 8'h1F;
    localparam logic [ByteW-1:0] Pay3Mask  = 8'h0F;
    localparam logic [ByteW-1:0] Pay4Mask  = 8'h07;
    localparam logic [ByteW-1:0] ContPay   = 8'h3F;

    // Continuation bytes still expected after each lead
    localparam logic [RemW-1:0] RemNone = 2'd0;
    localparam logic [RemW-1:0] RemOne  = 2'd1;
    localparam logic [RemW-1:0] RemTwo  = 2'd2;
    localparam logic [RemW-1:0] RemThree = 2'd3;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             end_of_text;
    } byte_item_t;

    typedef struct packed {
        logic [PointW-1:0] code_point;
        logic              point_valid;
        logic              text_done;
    } point_item_t;

    // Handshake between the input stage and the decode stage
    typedef struct packed {
        logic valid;
        logic take;
    } stage_ctl_t;

endpackage

// ===== src/u8d_ifs.sv =====
// Valid/ready channel interfaces for bytes in and code points out.
interface u8d_byte_if
    import u8d_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ByteW-1:0]    data_byte;
    logic                end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8d_point_if
    import u8d_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PointW-1:0]   code_point;
    logic                point_valid;
    logic                text_done;

    modport source (output valid, output code_point, output point_valid, output text_done,
                    input ready);
    modport sink   (input valid, input code_point, input point_valid, input text_done,
                    output ready);
endinterface

// ===== src/u8d_in_stage.sv =====
// Input register stage: holds one byte request until the decode stage takes it.
module u8d_in_stage
    import u8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    u8d_byte_if.sink        bytes,
    input  logic            take,
    output stage_ctl_t      ctl,
    output byte_item_t      item
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;
    logic       accept;

    // Accept a new request when empty or when the held byte moves on
    assign bytes.ready = !valid_reg || take;
    assign accept      = bytes.valid && bytes.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte   <= bytes.data_byte;
            item_reg.end_of_text <= bytes.end_of_text;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.take  = take;
    assign item      = item_reg;

endmodule

// ===== src/u8d_decode.sv =====
// Decode stage: sequence state and the per-byte lead/continuation logic.
module u8d_decode
    import u8d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  byte_item_t   item,
    input  logic         out_free,
    output logic         take,
    output logic         emit,
    output point_item_t  result
);

    logic [PointW-1:0] partial_reg;
    logic [PointW-1:0] partial_next;
    logic [RemW-1:0]   remain_reg;
    logic [RemW-1:0]   remain_next;
    logic [ByteW-1:0]  b;
    logic              is_cont;
    logic [PointW-1:0] shifted;
    logic [RemW-1:0]   remain_dec;
    logic              have;
    logic [PointW-1:0] cp;

    assign b          = item.data_byte;
    assign is_cont    = (remain_reg != RemNone) && ((b & ContMask) == ContCode);
    assign shifted    = {partial_reg[PointW-7:0], b[5:0]};
    assign remain_dec = remain_reg - RemOne;

    // Fold a continuation byte or start a new sequence
    always_comb
    begin
        partial_next = '0;
        remain_next  = RemNone;
        have         = 1'b0;
        cp           = '0;
        if (is_cont)
        begin
            remain_next = remain_dec;
            if (remain_dec == RemNone)
            begin
                have = 1'b1;
                cp   = shifted;
            end
            else
            begin
                partial_next = shifted;
            end
        end
        else if ((b & Ascii1Bit) == '0)
        begin
            have = 1'b1;
            cp   = {{(PointW-ByteW){1'b0}}, b};
        end
        else if ((b & Lead2Mask) == Lead2Code)
        begin
            partial_next = {{(PointW-ByteW){1'b0}}, b & Pay2Mask};
            remain_next  = RemOne;
        end
        else if ((b & Lead3Mask) == Lead3Code)
        begin
            partial_next = {{(PointW-ByteW){1'b0}}, b & Pay3Mask};
            remain_next  = RemTwo;
        end
        else if ((b & Lead4Mask) == Lead4Code)
        begin
            partial_next = {{(PointW-ByteW){1'b0}}, b & Pay4Mask};
            remain_next  = RemThree;
        end
        // Drop any pending sequence at end of text
        if (item.end_of_text)
        begin
            partial_next = '0;
            remain_next  = RemNone;
        end
    end

    // Advance unless a result is due and the output register is full
    assign emit = have || item.end_of_text;
    assign take = in_valid && (!emit || out_free);

    assign result.code_point  = cp;
    assign result.point_valid = have;
    assign result.text_done   = item.end_of_text;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            remain_reg  <= RemNone;
        end
        else if (take)
        begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

// ===== src/u8d_out_stage.sv =====
// Output register stage: holds one result request until the sink takes it.
module u8d_out_stage
    import u8d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  point_item_t  result,
    output logic         free,
    u8d_point_if.source  points
);

    logic        valid_reg;
    logic        valid_next;
    point_item_t result_reg;

    assign free = !valid_reg || points.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (points.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign points.valid       = valid_reg;
    assign points.code_point  = result_reg.code_point;
    assign points.point_valid = result_reg.point_valid;
    assign points.text_done   = result_reg.text_done;

endmodule

// ===== src/utf8_byte_stream_decoder.sv =====
// Top level of the UTF-8 byte stream decoder.
// Takes one UTF-8 byte per cycle on bytes, unless a result waits on a full output
// register, and emits code points on points. A byte is registered in the input
// stage, decoded against the pending sequence state, and any result lands in the
// output register. The rate is set by the single decode stage, which updates the
// sequence state once per byte. Bytes that only advance a sequence give no result.
// A byte flagged end_of_text always gives one result with text_done set, carrying
// a code point only if that byte completed one; a sequence cut short there is
// dropped and the next byte starts a fresh text. Invalid leads are discarded, and
// a non-continuation byte inside a sequence restarts decoding at that byte.
// Overlong forms and surrogates are passed through unchecked.
module utf8_byte_stream_decoder
    import u8d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    u8d_byte_if.sink     bytes,
    u8d_point_if.source  points
);

    `include "utf8_byte_stream_decoder_assert.svh"

    stage_ctl_t  in_ctl;
    byte_item_t  in_item;
    logic        take;
    logic        emit;
    logic        out_free;
    point_item_t result;

    u8d_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .take  (take),
        .ctl   (in_ctl),
        .item  (in_item)
    );

    u8d_decode u_dec (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ctl.valid),
        .item     (in_item),
        .out_free (out_free),
        .take     (take),
        .emit     (emit),
        .result   (result)
    );

    u8d_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_ctl.take && emit),
        .result (result),
        .free   (out_free),
        .points (points)
    );

    // A final byte that moves on must show up as a text_done result
    `U8D_ASSERT_NEXT(a_done_follows, in_ctl.take && in_item.end_of_text,
        points.valid && points.text_done)
    // A result without a code point carries zero
    `U8D_ASSERT_SAME(a_zero_when_empty, points.valid && !points.point_valid,
        points.code_point == '0)
    // A stalled input byte stays put
    `U8D_ASSERT_NEXT(a_in_hold, in_ctl.valid && !in_ctl.take,
        in_ctl.valid && $stable(in_item))

endmodule
